// ===== src/cdgc_pkg.sv =====
package cdgc_pkg;

  // Default sizes, handed to the top level parameters
  localparam int DEF_MAX_CHANNELS  = 32;
  localparam int DEF_MAX_TAPS      = 8;
  localparam int DEF_HISTORY_DEPTH = 128;
  localparam int DEF_SAMPLE_BITS   = 24;

  // Fixed point and register limits
  localparam int FRAC_BITS    = 20;
  localparam int MAX_DILATION = 16;
  localparam int MAX_GROUPS   = 32;
  localparam int PS_W         = 8;
  localparam int DIL_W        = 5;
  localparam int GRP_W        = 6;

  // Fixed field widths
  localparam int REQ_W     = 2;
  localparam int IDX_W     = 13;
  localparam int OUT_CH_W  = 5;
  localparam int IN_USER_W = REQ_W + 1;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 6;

  localparam logic [CFG_AW-1:0] CFG_IN_CH  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_OUT_CH = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_TAPS   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_DIL    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_GROUPS = 3'd4;

  // Request kinds carried in tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_WEIGHT = 2'd0,
    REQ_BIAS   = 2'd1,
    REQ_SAMPLE = 2'd2
  } req_t;

  // Register value clamped into 1..hi
  function automatic logic [15:0] clamp_cfg(input logic [CFG_DW-1:0] v, input int hi);
    if (v == '0) begin
      return 16'd1;
    end else if (int'(v) > hi) begin
      return 16'(hi);
    end else begin
      return 16'(v);
    end
  endfunction

endpackage

// ===== src/causal_dilated_grouped_conv1d.sv =====
// Channel   Dir  Beat fields (low bit first)
// in_       in   tdata: index, sample_value; tuser: req_type, sequence_start
// out_      out  tdata: out_channel, result_value; tuser: saturated; tlast: last
// cfg_      in   write enable, register index, write data
//
// Weight, bias and non-final sample beats are accepted while idle.
// The final input channel of a position starts a run: the channels not pushed are
// zeroed and the channels are split into groups, then each output channel sums n
// products onto its bias, n being the taps in reach times channels per group.
// A single multiply-accumulate forms one product per cycle.
// Reset is synchronous; in_tready is low for the whole run, out_tready low stalls it.
module causal_dilated_grouped_conv1d
  import cdgc_pkg::*;
#(
  parameter int MAX_CHANNELS  = DEF_MAX_CHANNELS,
  parameter int MAX_TAPS      = DEF_MAX_TAPS,
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                in_tvalid,
  output logic                                                in_tready,
  // index, sample_value
  input  logic [((IDX_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0]    in_tdata,
  // req_type, sequence_start
  input  logic [IN_USER_W-1:0]                                in_tuser,
  output logic                                                out_tvalid,
  input  logic                                                out_tready,
  // out_channel, result_value
  output logic [((OUT_CH_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  // saturated
  output logic [0:0]                                          out_tuser,
  output logic                                                out_tlast,
  input  logic                                                cfg_we,
  input  logic [CFG_AW-1:0]                                   cfg_addr,
  input  logic [CFG_DW-1:0]                                   cfg_wdata
);

  localparam int OUT_DW       = ((OUT_CH_W + SAMPLE_BITS + 7) / 8) * 8;
  localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
  localparam int TAP_W        = $clog2(MAX_TAPS + 1);
  localparam int SLOT_W       = $clog2(HISTORY_DEPTH);
  localparam int HIST_AW      = CH_W + SLOT_W;
  localparam int HIST_DEPTH   = 1 << HIST_AW;
  localparam int WEIGHT_DEPTH = MAX_CHANNELS * MAX_CHANNELS * MAX_TAPS;
  localparam int W_AW         = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int DLY_W        = $clog2(MAX_TAPS * MAX_DILATION + 1);
  localparam int DIV_W        = ((CNT_W > GRP_W) ? CNT_W : GRP_W) + 1;
  localparam int CMP_W        = 16;
  localparam int PROD_W       = 2 * SAMPLE_BITS;
  localparam int ACC_W        = ((PROD_W > SAMPLE_BITS + FRAC_BITS) ? PROD_W
                                 : SAMPLE_BITS + FRAC_BITS)
                                + $clog2(MAX_CHANNELS * MAX_TAPS + 1) + 1;
  localparam logic signed [ACC_W-1:0] Q_MAX =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] Q_MIN = -Q_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_LOAD,
    S_ISSUE,
    S_DRAIN,
    S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [5:0] cfg_in_ch_r, cfg_out_ch_r, cfg_groups_r;
  logic [3:0] cfg_taps_r;
  logic [4:0] cfg_dil_r;

  logic [CNT_W-1:0] ic_eff, oc_eff;
  logic [TAP_W-1:0] kt_eff;
  logic [DIL_W-1:0] dil_eff;
  logic [GRP_W-1:0] grp_eff;

  // Position state
  logic [SLOT_W-1:0]             ptr_r;
  logic [PS_W-1:0]               ps_r;
  logic [MAX_CHANNELS-1:0]       vbit_r;
  logic signed [SAMPLE_BITS-1:0] bias_r [MAX_CHANNELS];

  // Run counters
  logic [CNT_W-1:0] fill_cnt_r;
  logic [DIV_W-1:0] si_r, so_r;
  logic [CNT_W-1:0] qi_r, qo_r, ipg_r, opg_r;
  logic [CNT_W-1:0] o_r, ogc_r, chbase_r, c_r;
  logic [TAP_W-1:0] j_r;
  logic [DLY_W-1:0] delay_r;
  logic [W_AW:0]    wbase_r;

  // MAC pipeline
  logic                          v1_r, v2_r;
  logic signed [SAMPLE_BITS-1:0] w_q, h_q;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r;

  // Output register
  logic                          out_tvalid_r;
  logic [OUT_CH_W-1:0]           out_ch_r;
  logic signed [SAMPLE_BITS-1:0] out_val_r;
  logic                          out_sat_r;
  logic                          out_last_r;

  // Input beat decode
  logic                          in_acc;
  req_t                          req;
  logic                          seq_start;
  logic [IDX_W-1:0]              in_idx;
  logic signed [SAMPLE_BITS-1:0] in_val;
  logic                          smp_ok, smp_last;

  assign in_acc    = in_tvalid && in_tready;
  assign req       = req_t'(in_tuser[REQ_W-1:0]);
  assign seq_start = in_tuser[REQ_W];
  assign in_idx    = in_tdata[IDX_W-1:0];
  assign in_val    = in_tdata[IDX_W +: SAMPLE_BITS];
  assign smp_ok    = in_acc && (req == REQ_SAMPLE) && (CMP_W'(in_idx) < CMP_W'(ic_eff));
  assign smp_last  = smp_ok && (CMP_W'(in_idx) == CMP_W'(ic_eff) - CMP_W'(1));

  // Effective register values
  assign ic_eff  = CNT_W'(clamp_cfg(cfg_in_ch_r, MAX_CHANNELS));
  assign oc_eff  = CNT_W'(clamp_cfg(cfg_out_ch_r, MAX_CHANNELS));
  assign kt_eff  = TAP_W'(clamp_cfg(CFG_DW'(cfg_taps_r), MAX_TAPS));
  assign dil_eff = DIL_W'(clamp_cfg(CFG_DW'(cfg_dil_r), MAX_DILATION));
  assign grp_eff = GRP_W'(clamp_cfg(cfg_groups_r, MAX_GROUPS));

  // Group split progress
  logic fill_done, div_done;
  assign fill_done = (fill_cnt_r == CNT_W'(MAX_CHANNELS));
  assign div_done  = (si_r >= DIV_W'(ic_eff)) && (so_r >= DIV_W'(oc_eff));

  // Tap walk: delay grows from zero, tap index runs down from the newest
  logic [TAP_W-1:0]  tap_idx;
  logic [W_AW:0]     waddr_full;
  logic [W_AW-1:0]   waddr;
  logic [CNT_W-1:0]  ch_sum;
  logic [CMP_W-1:0]  slot_full, nd;
  logic [HIST_AW-1:0] haddr;
  logic              tap_end, c_last, o_last, issue;

  assign tap_idx    = kt_eff - TAP_W'(1) - j_r;
  assign waddr_full = wbase_r + (W_AW + 1)'(tap_idx);
  assign waddr      = waddr_full[W_AW-1:0];
  assign ch_sum     = chbase_r + c_r;
  assign slot_full  = (CMP_W'(ptr_r) >= CMP_W'(delay_r))
                      ? CMP_W'(ptr_r) - CMP_W'(delay_r)
                      : CMP_W'(ptr_r) + CMP_W'(HISTORY_DEPTH) - CMP_W'(delay_r);
  assign haddr      = {ch_sum[CH_W-1:0], slot_full[SLOT_W-1:0]};
  assign nd         = CMP_W'(delay_r) + CMP_W'(dil_eff);
  assign tap_end    = (j_r == kt_eff - TAP_W'(1)) || (nd > CMP_W'(ps_r))
                      || (nd >= CMP_W'(HISTORY_DEPTH));
  assign c_last     = (c_r == ipg_r - CNT_W'(1));
  assign o_last     = (o_r == oc_eff - CNT_W'(1));
  assign issue      = (state_r == S_ISSUE);

  // Round half up, then clip
  logic signed [ACC_W-1:0]       rnd, q;
  logic                          sat_hi, sat_lo;
  logic signed [SAMPLE_BITS-1:0] res_val;

  assign rnd     = acc_r + HALF_LSB;
  assign q       = rnd >>> FRAC_BITS;
  assign sat_hi  = (q > Q_MAX);
  assign sat_lo  = (q < Q_MIN);
  assign res_val = sat_hi ? Q_MAX[SAMPLE_BITS-1:0]
                 : sat_lo ? Q_MIN[SAMPLE_BITS-1:0] : q[SAMPLE_BITS-1:0];

  // Weight store
  logic signed [SAMPLE_BITS-1:0] wmem [WEIGHT_DEPTH];
  logic                          w_we;

  assign w_we = in_acc && (req == REQ_WEIGHT) && (int'(in_idx) < WEIGHT_DEPTH);

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[W_AW'(in_idx)] <= in_val;
    end
    if (issue) begin
      w_q <= wmem[waddr];
    end
  end

  // Sample history: one row per channel, one slot per position
  logic signed [SAMPLE_BITS-1:0] hmem [HIST_DEPTH];
  logic                          h_we;
  logic [HIST_AW-1:0]            h_waddr;
  logic signed [SAMPLE_BITS-1:0] h_wdata;

  always_comb begin
    h_we    = 1'b0;
    h_waddr = {in_idx[CH_W-1:0], ptr_r};
    h_wdata = in_val;
    if (smp_ok) begin
      h_we = 1'b1;
    end else if ((state_r == S_PREP) && !fill_done && !vbit_r[fill_cnt_r[CH_W-1:0]]) begin
      // channel not pushed at this position reads zero later
      h_we    = 1'b1;
      h_waddr = {fill_cnt_r[CH_W-1:0], ptr_r};
      h_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    if (issue) begin
      h_q <= hmem[haddr];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_in_ch_r  <= 6'd1;
      cfg_out_ch_r <= 6'd1;
      cfg_taps_r   <= 4'd1;
      cfg_dil_r    <= 5'd1;
      cfg_groups_r <= 6'd1;
      ptr_r        <= '0;
      ps_r         <= '0;
      vbit_r       <= '0;
      bias_r       <= '{default: '0};
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_IN_CH:  cfg_in_ch_r  <= cfg_wdata;
          CFG_OUT_CH: cfg_out_ch_r <= cfg_wdata;
          CFG_TAPS:   cfg_taps_r   <= cfg_wdata[3:0];
          CFG_DIL:    cfg_dil_r    <= cfg_wdata[4:0];
          CFG_GROUPS: cfg_groups_r <= cfg_wdata;
          default: ;
        endcase
      end

      // MAC pipeline: read, multiply, accumulate
      v1_r   <= issue;
      v2_r   <= v1_r;
      prod_r <= PROD_W'(w_q) * PROD_W'(h_q);
      if (v2_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end

      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc && (req == REQ_BIAS) && (int'(in_idx) < MAX_CHANNELS)) begin
            bias_r[in_idx[CH_W-1:0]] <= in_val;
          end
          if (smp_ok) begin
            if (seq_start) begin
              ps_r <= '0;
            end
            vbit_r[in_idx[CH_W-1:0]] <= 1'b1;
            if (smp_last) begin
              fill_cnt_r <= '0;
              si_r       <= '0;
              so_r       <= '0;
              qi_r       <= '0;
              qo_r       <= '0;
              state_r    <= S_PREP;
            end
          end
        end

        S_PREP: begin
          if (!fill_done) begin
            fill_cnt_r <= fill_cnt_r + CNT_W'(1);
          end
          // channels per group by repeated add
          if (si_r < DIV_W'(ic_eff)) begin
            si_r <= si_r + DIV_W'(grp_eff);
            qi_r <= qi_r + CNT_W'(1);
          end
          if (so_r < DIV_W'(oc_eff)) begin
            so_r <= so_r + DIV_W'(grp_eff);
            qo_r <= qo_r + CNT_W'(1);
          end
          if (fill_done && div_done) begin
            if ((si_r == DIV_W'(ic_eff)) && (so_r == DIV_W'(oc_eff))) begin
              ipg_r <= qi_r;
              opg_r <= qo_r;
            end else begin
              // groups does not divide both counts: one group
              ipg_r <= ic_eff;
              opg_r <= oc_eff;
            end
            o_r      <= '0;
            ogc_r    <= '0;
            chbase_r <= '0;
            wbase_r  <= '0;
            state_r  <= S_LOAD;
          end
        end

        S_LOAD: begin
          acc_r   <= ACC_W'(bias_r[o_r[CH_W-1:0]]) <<< FRAC_BITS;
          c_r     <= '0;
          j_r     <= '0;
          delay_r <= '0;
          state_r <= S_ISSUE;
        end

        S_ISSUE: begin
          if (tap_end) begin
            j_r     <= '0;
            delay_r <= '0;
            c_r     <= c_r + CNT_W'(1);
            wbase_r <= wbase_r + (W_AW + 1)'(kt_eff);
            if (c_last) begin
              state_r <= S_DRAIN;
            end
          end else begin
            j_r     <= j_r + TAP_W'(1);
            delay_r <= DLY_W'(nd);
          end
        end

        S_DRAIN: begin
          if (!v1_r && !v2_r) begin
            state_r <= S_OUT;
          end
        end

        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_ch_r     <= OUT_CH_W'(o_r);
            out_val_r    <= res_val;
            out_sat_r    <= sat_hi || sat_lo;
            out_last_r   <= o_last;
            if (o_last) begin
              // close the position
              ptr_r   <= (ptr_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_r + SLOT_W'(1);
              vbit_r  <= '0;
              if (ps_r != {PS_W{1'b1}}) begin
                ps_r <= ps_r + PS_W'(1);
              end
              state_r <= S_IDLE;
            end else begin
              o_r <= o_r + CNT_W'(1);
              if (ogc_r == opg_r - CNT_W'(1)) begin
                ogc_r    <= '0;
                chbase_r <= chbase_r + ipg_r;
              end else begin
                ogc_r <= ogc_r + CNT_W'(1);
              end
              state_r <= S_LOAD;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DW'({out_val_r, out_ch_r});
  assign out_tuser  = out_sat_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/cdgc_checker.sv =====
module cdgc_checker
  import cdgc_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input logic                                                clk,
  input logic                                                rst_n,
  input logic                                                in_tvalid,
  input logic                                                in_tready,
  input logic [IN_USER_W-1:0]                                in_tuser,
  input logic                                                out_tvalid,
  input logic                                                out_tready,
  input logic [((OUT_CH_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  input logic [0:0]                                          out_tuser,
  input logic                                                out_tlast
);

  localparam logic [SAMPLE_BITS-1:0] VAL_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] VAL_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // Reset leaves no result pending and the input open
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("state after reset wrong");

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed under stall");

  // Mid-position results mean the run is still going
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open before position finished");

  // A clipped result sits at a rail
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_tdata[OUT_CH_W +: SAMPLE_BITS] == VAL_MAX)
      || (out_tdata[OUT_CH_W +: SAMPLE_BITS] == VAL_MIN))
    else $error("saturated flag on unclipped value");

  // Only a sample beat can start a run
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid) && ($past(in_tuser[REQ_W-1:0]) == REQ_SAMPLE))
    else $error("run started without a sample beat");

endmodule

bind causal_dilated_grouped_conv1d cdgc_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_cdgc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
